// ===== hw/rtl/ttpt_pkg.sv =====
// ----------------------------------------------------------------------------
// ttpt_pkg
// Shared widths, codes, segment tables and item types for the timber thermal
// property tables block.
// ----------------------------------------------------------------------------
package ttpt_pkg;

	localparam int TEMP_W     = 17;
	localparam int COND_W     = 17;
	localparam int DENS_W     = 20;
	localparam int HEAT_W     = 18;
	localparam int DRY_W      = 10;
	localparam int MOIST_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_DRY_DENSITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MOISTURE    = 2'd1;

	// w = 5*T - 87408: Celsius in units of 1/320 C (exact for T in 1/64 K)
	localparam int W_W = 21;
	localparam logic signed [W_W-1:0] W_OFFSET    = 21'sd87408;
	localparam logic signed [W_W-1:0] W_TOP       = 21'sd384000;  // 1200 C
	localparam logic signed [W_W-1:0] W_MOIST_TOP = 21'sd32000;   // 100 C

	localparam int COND_N  = 6;
	localparam int DENS_N  = 8;
	localparam int HEAT_N  = 13;
	localparam int COND_IW = 3;
	localparam int DENS_IW = 3;
	localparam int HEAT_IW = 4;

	// heat 600..800 C segment: base 89.6e6, numerator up to 105.6e6
	localparam int BASE_W = 27;
	localparam int DY_W   = 16;
	localparam int T0_W   = 18;
	localparam int U_W    = 18;
	localparam int M_W    = 27;
	localparam int X_W    = 34;
	localparam int D_W    = 17;
	localparam int R_W    = 29;
	localparam int Q_W    = 18;
	localparam int DIV_K  = 34;
	localparam int RHO_W  = 20;

	localparam logic [63:0] DIV_ONE = 64'd1 << DIV_K;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// base = 320*y0*span, t0x = 320*t0, dhalf = half divisor, recip = 2^34 / divisor
	typedef struct packed {
		logic [BASE_W-1:0] base;
		logic [DY_W-1:0]   dy;
		logic [T0_W-1:0]   t0x;
		logic [D_W-1:0]    dhalf;
		logic [R_W-1:0]    recip;
	} seg_t;

	typedef struct packed {
		logic [W_W-1:0]     w;
		logic [COND_IW-1:0] cond_idx;
		logic [DENS_IW-1:0] dens_idx;
		logic [HEAT_IW-1:0] heat_idx;
		logic               oor;
		logic               low;
	} item_t;

	typedef struct packed {
		logic [BASE_W-1:0] base;
		logic [DY_W-1:0]   dy;
		logic [U_W-1:0]    u;
		logic [D_W-1:0]    dhalf;
		logic [R_W-1:0]    recip;
	} curve_s1_t;

	typedef struct packed {
		logic [M_W-1:0] m;
		logic [D_W-1:0] dhalf;
		logic [R_W-1:0] recip;
	} curve_s2_t;

	typedef struct packed {
		logic [X_W-1:0] x;
		logic [D_W-1:0] d;
		logic [R_W-1:0] r;
	} div_in_t;

	// conductivity: divisor 250*span
	localparam seg_t COND_SEG [COND_N] = '{
		'{27'(320*12*1),   16'(0),   18'(320*20),  17'(125*1),
			29'(DIV_ONE / 64'(250*1))},
		'{27'(320*12*180), 16'(3),   18'(320*20),  17'(125*180),
			29'(DIV_ONE / 64'(250*180))},
		'{27'(320*15*150), 16'(-8),  18'(320*200), 17'(125*150),
			29'(DIV_ONE / 64'(250*150))},
		'{27'(320*7*150),  16'(2),   18'(320*350), 17'(125*150),
			29'(DIV_ONE / 64'(250*150))},
		'{27'(320*9*300),  16'(26),  18'(320*500), 17'(125*300),
			29'(DIV_ONE / 64'(250*300))},
		'{27'(320*35*400), 16'(115), 18'(320*800), 17'(125*400),
			29'(DIV_ONE / 64'(250*400))}
	};

	// relative density above 100 C: divisor 250*span
	localparam seg_t DENS_SEG [DENS_N] = '{
		'{27'(320*100*1),  16'(0),   18'(320*200), 17'(125*1),
			29'(DIV_ONE / 64'(250*1))},
		'{27'(320*100*50), 16'(-7),  18'(320*200), 17'(125*50),
			29'(DIV_ONE / 64'(250*50))},
		'{27'(320*93*50),  16'(-17), 18'(320*250), 17'(125*50),
			29'(DIV_ONE / 64'(250*50))},
		'{27'(320*76*50),  16'(-24), 18'(320*300), 17'(125*50),
			29'(DIV_ONE / 64'(250*50))},
		'{27'(320*52*50),  16'(-14), 18'(320*350), 17'(125*50),
			29'(DIV_ONE / 64'(250*50))},
		'{27'(320*38*200), 16'(-10), 18'(320*400), 17'(125*200),
			29'(DIV_ONE / 64'(250*200))},
		'{27'(320*28*200), 16'(-2),  18'(320*600), 17'(125*200),
			29'(DIV_ONE / 64'(250*200))},
		'{27'(320*26*400), 16'(-26), 18'(320*800), 17'(125*400),
			29'(DIV_ONE / 64'(250*400))}
	};

	// specific heat: divisor 40*span; the 129..200 C segment starts at 121 C
	localparam seg_t HEAT_SEG [HEAT_N] = '{
		'{27'(320*1530*1),   16'(0),      18'(320*20),  17'(20*1),
			29'(DIV_ONE / 64'(40*1))},
		'{27'(320*1530*79),  16'(240),    18'(320*20),  17'(20*79),
			29'(DIV_ONE / 64'(40*79))},
		'{27'(320*1770*10),  16'(11830),  18'(320*99),  17'(20*10),
			29'(DIV_ONE / 64'(40*10))},
		'{27'(320*13600*10), 16'(-100),   18'(320*109), 17'(20*10),
			29'(DIV_ONE / 64'(40*10))},
		'{27'(320*13500*10), 16'(-11380), 18'(320*119), 17'(20*10),
			29'(DIV_ONE / 64'(40*10))},
		'{27'(320*2120*79),  16'(-120),   18'(320*121), 17'(20*79),
			29'(DIV_ONE / 64'(40*79))},
		'{27'(320*2000*50),  16'(-380),   18'(320*200), 17'(20*50),
			29'(DIV_ONE / 64'(40*50))},
		'{27'(320*1620*50),  16'(-910),   18'(320*250), 17'(20*50),
			29'(DIV_ONE / 64'(40*50))},
		'{27'(320*710*50),   16'(140),    18'(320*300), 17'(20*50),
			29'(DIV_ONE / 64'(40*50))},
		'{27'(320*850*50),   16'(150),    18'(320*350), 17'(20*50),
			29'(DIV_ONE / 64'(40*50))},
		'{27'(320*1000*200), 16'(400),    18'(320*400), 17'(20*200),
			29'(DIV_ONE / 64'(40*200))},
		'{27'(320*1400*200), 16'(250),    18'(320*600), 17'(20*200),
			29'(DIV_ONE / 64'(40*200))},
		'{27'(320*1650*1),   16'(0),      18'(320*800), 17'(20*1),
			29'(DIV_ONE / 64'(40*1))}
	};

	// upper breakpoints (w units) of all but the last segment
	localparam logic signed [W_W-1:0] COND_HI [COND_N-1] = '{
		21'(320*20), 21'(320*200), 21'(320*350), 21'(320*500), 21'(320*800)
	};

	localparam logic signed [W_W-1:0] DENS_HI [DENS_N-1] = '{
		21'(320*200), 21'(320*250), 21'(320*300), 21'(320*350),
		21'(320*400), 21'(320*600), 21'(320*800)
	};

	localparam logic signed [W_W-1:0] HEAT_HI [HEAT_N-1] = '{
		21'(320*20),  21'(320*99),  21'(320*109), 21'(320*119),
		21'(320*129), 21'(320*200), 21'(320*250), 21'(320*300),
		21'(320*350), 21'(320*400), 21'(320*600), 21'(320*800)
	};

endpackage

// ===== hw/rtl/ttpt_front.sv =====
// ----------------------------------------------------------------------------
// ttpt_front
// Converts the kelvin sample to the internal Celsius scale and picks the
// segment of each property curve.
// ----------------------------------------------------------------------------
module ttpt_front
	import ttpt_pkg::*;
(
	input  logic              sample_valid,
	input  logic [TEMP_W-1:0] temp_kelvin,
	input  logic              queue_full,
	output logic              sample_stall,
	output logic              push,
	output item_t             push_item
);

	logic [W_W-2:0]        t5;
	logic signed [W_W-1:0] w;
	logic [COND_IW-1:0]    cond_idx;
	logic [DENS_IW-1:0]    dens_idx;
	logic [HEAT_IW-1:0]    heat_idx;

	assign t5 = 20'(temp_kelvin) * 20'd5;
	assign w  = $signed({1'b0, t5}) - W_OFFSET;

	// a value on a breakpoint stays in the lower segment
	always_comb begin
		cond_idx = '0;
		dens_idx = '0;
		heat_idx = '0;
		for (int i = 0; i < COND_N - 1; i++) begin
			if (w > COND_HI[i]) cond_idx = cond_idx + COND_IW'(1);
		end
		for (int i = 0; i < DENS_N - 1; i++) begin
			if (w > DENS_HI[i]) dens_idx = dens_idx + DENS_IW'(1);
		end
		for (int i = 0; i < HEAT_N - 1; i++) begin
			if (w > HEAT_HI[i]) heat_idx = heat_idx + HEAT_IW'(1);
		end
	end

	assign sample_stall = queue_full;
	assign push         = sample_valid && !queue_full;

	always_comb begin
		push_item.w        = w;
		push_item.cond_idx = cond_idx;
		push_item.dens_idx = dens_idx;
		push_item.heat_idx = heat_idx;
		push_item.oor      = (w > W_TOP);
		push_item.low      = (w <= W_MOIST_TOP);
	end

endmodule

// ===== hw/rtl/ttpt_queue.sv =====
// ----------------------------------------------------------------------------
// ttpt_queue
// Short FIFO of classified samples between the front and the back.
// ----------------------------------------------------------------------------
module ttpt_queue
	import ttpt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output logic  full,
	output logic  head_valid,
	output item_t head_item
);

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/ttpt_div.sv =====
// ----------------------------------------------------------------------------
// ttpt_div
// Three-stage divide by a segment constant: reciprocal multiply split into two
// partial products over the 17-bit halves of the numerator, then one remainder check.
// ----------------------------------------------------------------------------
module ttpt_div
	import ttpt_pkg::*;
(
	input  logic           clk,
	input  logic           en,
	input  div_in_t        operand,
	output logic [Q_W-1:0] quot
);

	localparam int HALF_W = X_W / 2;
	localparam int PP_W   = HALF_W + R_W;
	localparam int SUM_W  = PP_W + HALF_W;

	logic [PP_W-1:0]  p_hi_s1;
	logic [PP_W-1:0]  p_lo_s1;
	logic [X_W-1:0]   x_s1;
	logic [D_W-1:0]   d_s1;
	logic [SUM_W-1:0] sum;
	logic [Q_W-1:0]   q0_s2;
	logic [X_W-1:0]   x_s2;
	logic [D_W-1:0]   d_s2;
	logic [X_W:0]     prod;
	logic [X_W-1:0]   rem;
	logic [Q_W-1:0]   quot_s3;

	assign sum  = {p_hi_s1, HALF_W'(0)} + SUM_W'(p_lo_s1);
	assign prod = (X_W + 1)'(q0_s2) * (X_W + 1)'(d_s2);
	assign rem  = x_s2 - prod[X_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			p_hi_s1 <= PP_W'(operand.x[X_W-1:HALF_W]) * PP_W'(operand.r);
			p_lo_s1 <= PP_W'(operand.x[HALF_W-1:0]) * PP_W'(operand.r);
			x_s1    <= operand.x;
			d_s1    <= operand.d;
			// estimate is exact or one low
			q0_s2   <= sum[DIV_K +: Q_W];
			x_s2    <= x_s1;
			d_s2    <= d_s1;
			quot_s3 <= (rem >= X_W'(d_s2)) ? q0_s2 + Q_W'(1) : q0_s2;
		end
	end

	assign quot = quot_s3;

endmodule

// ===== hw/rtl/ttpt_back.sv =====
// ----------------------------------------------------------------------------
// ttpt_back
// Evaluates the three property curves for one classified sample per cycle while
// no result is held, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module ttpt_back
	import ttpt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  item_t              head_item,
	output logic               pop,
	input  logic [DRY_W-1:0]   dry_density,
	input  logic [MOIST_W-1:0] moisture_fraction,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [COND_W-1:0]  conductivity,
	output logic [DENS_W-1:0]  density,
	output logic [HEAT_W-1:0]  specific_heat,
	output logic               out_of_range
);

	function automatic curve_s1_t seg_to_s1(seg_t sg, logic [W_W-1:0] w, logic oor);
		logic signed [W_W-1:0] diff;
		curve_s1_t c;
		diff    = $signed(w) - $signed({3'b000, sg.t0x});
		c.base  = sg.base;
		c.dy    = sg.dy;
		c.u     = (sg.dy == '0 || oor) ? '0 : diff[U_W-1:0];
		c.dhalf = sg.dhalf;
		c.recip = sg.recip;
		return c;
	endfunction

	function automatic curve_s2_t s1_to_s2(curve_s1_t c);
		logic signed [DY_W+U_W:0]   prod;
		logic signed [DY_W+U_W+1:0] sum;
		curve_s2_t r;
		prod    = $signed(c.dy) * $signed({1'b0, c.u});
		sum     = $signed({(DY_W + U_W + 2 - BASE_W)'(0), c.base}) + prod;
		r.m     = sum[DY_W+U_W+1] ? '0 : sum[M_W-1:0];
		r.dhalf = c.dhalf;
		r.recip = c.recip;
		return r;
	endfunction

	logic adv;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic [1:0] flags_s1, flags_s2, flags_s3, flags_s4, flags_s5, flags_s6;  // {oor, low}
	logic [RHO_W-1:0] rho_s2, rho_s3, rho_s4, rho_s5, rho_s6;
	curve_s1_t cond_s1, dens_s1, heat_s1;
	curve_s2_t cond_s2, dens_s2, heat_s2;
	div_in_t   cond_s3, dens_s3, heat_s3;
	logic [27:0]    moist_prod;
	logic [X_W-1:0] dens_n;
	logic [Q_W-1:0] cond_q, dens_q, heat_q;

	// whole back moves together; only a held result stops it
	assign adv = !valid_s6 || !result_stall;
	assign pop = adv && head_valid;

	assign moist_prod = 28'(dry_density) * 28'({1'b1, moisture_fraction}) + 28'd128;
	assign dens_n     = X_W'(dens_s2.m) * X_W'(dry_density);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= head_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cond_s1  <= seg_to_s1(COND_SEG[head_item.cond_idx], head_item.w, head_item.oor);
			dens_s1  <= seg_to_s1(DENS_SEG[head_item.dens_idx], head_item.w, head_item.oor);
			heat_s1  <= seg_to_s1(HEAT_SEG[head_item.heat_idx], head_item.w, head_item.oor);
			flags_s1 <= {head_item.oor, head_item.low};

			cond_s2  <= s1_to_s2(cond_s1);
			dens_s2  <= s1_to_s2(dens_s1);
			heat_s2  <= s1_to_s2(heat_s1);
			rho_s2   <= moist_prod[27:8];
			flags_s2 <= flags_s1;

			// rounding numerators: 2*N + divisor/2
			cond_s3.x <= X_W'({cond_s2.m, 9'b0}) + X_W'(cond_s2.dhalf);
			cond_s3.d <= {cond_s2.dhalf[D_W-2:0], 1'b0};
			cond_s3.r <= cond_s2.recip;
			dens_s3.x <= {dens_n[X_W-2:0], 1'b0} + X_W'(dens_s2.dhalf);
			dens_s3.d <= {dens_s2.dhalf[D_W-2:0], 1'b0};
			dens_s3.r <= dens_s2.recip;
			heat_s3.x <= X_W'({heat_s2.m, 1'b0}) + X_W'(heat_s2.dhalf);
			heat_s3.d <= {heat_s2.dhalf[D_W-2:0], 1'b0};
			heat_s3.r <= heat_s2.recip;
			rho_s3    <= rho_s2;
			flags_s3  <= flags_s2;

			rho_s4   <= rho_s3;
			flags_s4 <= flags_s3;
			rho_s5   <= rho_s4;
			flags_s5 <= flags_s4;
			rho_s6   <= rho_s5;
			flags_s6 <= flags_s5;
		end
	end

	ttpt_div u_cond_div (.clk(clk), .en(adv), .operand(cond_s3), .quot(cond_q));
	ttpt_div u_dens_div (.clk(clk), .en(adv), .operand(dens_s3), .quot(dens_q));
	ttpt_div u_heat_div (.clk(clk), .en(adv), .operand(heat_s3), .quot(heat_q));

	assign result_valid  = valid_s6;
	assign out_of_range  = flags_s6[1];
	assign conductivity  = flags_s6[1] ? '0 : cond_q[COND_W-1:0];
	assign specific_heat = flags_s6[1] ? '0 : heat_q[HEAT_W-1:0];
	assign density       = flags_s6[1] ? '0 :
		(flags_s6[0] ? rho_s6 : dens_q[DENS_W-1:0]);

endmodule

// ===== hw/rtl/timber_thermal_property_tables.sv =====
// ----------------------------------------------------------------------------
// timber_thermal_property_tables: timber conductivity, density, specific heat
// Throughput: one sample per cycle while no result is held, set by the pipelined reciprocal dividers.
// Reset: asynchronous, clears the queue, the pipeline valids and both registers.
// ----------------------------------------------------------------------------
module timber_thermal_property_tables
	import ttpt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  logic [TEMP_W-1:0]     temp_kelvin,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [COND_W-1:0]     conductivity,
	output logic [DENS_W-1:0]     density,
	output logic [HEAT_W-1:0]     specific_heat,
	output logic                  out_of_range
);

	logic [DRY_W-1:0]   dry_density_q;
	logic [MOIST_W-1:0] moisture_q;
	logic               queue_full;
	logic               push;
	item_t              push_item;
	logic               pop;
	logic               head_valid;
	item_t              head_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dry_density_q <= '0;
			moisture_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DRY_DENSITY: dry_density_q <= cfg_data[DRY_W-1:0];
				CFG_MOISTURE:    moisture_q    <= cfg_data[MOIST_W-1:0];
				default:         ;
			endcase
		end
	end

	ttpt_front u_front (
		.sample_valid (sample_valid),
		.temp_kelvin  (temp_kelvin),
		.queue_full   (queue_full),
		.sample_stall (sample_stall),
		.push         (push),
		.push_item    (push_item)
	);

	ttpt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	ttpt_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.head_valid        (head_valid),
		.head_item         (head_item),
		.pop               (pop),
		.dry_density       (dry_density_q),
		.moisture_fraction (moisture_q),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.conductivity      (conductivity),
		.density           (density),
		.specific_heat     (specific_heat),
		.out_of_range      (out_of_range)
	);

endmodule

// ===== bench/tb_timber_thermal_property_tables.sv =====
// ----------------------------------------------------------------------------
// tb_timber_thermal_property_tables
// Self-checking bench for the timber property curves. Temperatures go in on a
// valid/stall channel; a scoreboard predicts conductivity, density and heat
// for each accepted sample and checks results in order, across several
// register settings, with bursty input, random output stalls and back-pressure.
// ----------------------------------------------------------------------------
module tb_timber_thermal_property_tables;
	import ttpt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam longint C_STEP     = 6400;     // internal temperature units per C
	localparam longint KELVIN_OFS = 1748160;  // 273.15 C in those units
	localparam int     ZERO_C_RAW = 17481;    // input code just below 0 C
	localparam int     CYCLE_LIMIT = 400000;
	localparam int     HOLD_CYCLES = 400;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	typedef struct packed {
		logic [COND_W-1:0] cond;
		logic [DENS_W-1:0] dens;
		logic [HEAT_W-1:0] heat;
		logic              oor;
	} props_t;

	typedef struct {
		longint y0;
		longint dy;
		longint t0;
		longint span;
	} line_seg_t;

	class thermal_scoreboard;
		props_t expected_props[$];
		longint dry_density = 0;
		longint moisture = 0;
		int     errors = 0;

		function void report(string what, longint got, longint want);
			errors++;
			if (errors <= 100)
				$display("tb: mismatch %s got %0d expected %0d", what, got, want);
		endfunction

		function line_seg_t seg(longint y0, longint dy, longint t0, longint span);
			line_seg_t s;
			s.y0 = y0;
			s.dy = dy;
			s.t0 = t0;
			s.span = span;
			return s;
		endfunction

		function line_seg_t cond_seg(longint tc);
			if (tc <= 20 * C_STEP) return seg(12, 0, 20, 1);
			else if (tc <= 200 * C_STEP) return seg(12, 3, 20, 180);
			else if (tc <= 350 * C_STEP) return seg(15, -8, 200, 150);
			else if (tc <= 500 * C_STEP) return seg(7, 2, 350, 150);
			else if (tc <= 800 * C_STEP) return seg(9, 26, 500, 300);
			else return seg(35, 115, 800, 400);
		endfunction

		function line_seg_t dens_seg(longint tc);
			if (tc <= 200 * C_STEP) return seg(100, 0, 200, 1);
			else if (tc <= 250 * C_STEP) return seg(100, -7, 200, 50);
			else if (tc <= 300 * C_STEP) return seg(93, -17, 250, 50);
			else if (tc <= 350 * C_STEP) return seg(76, -24, 300, 50);
			else if (tc <= 400 * C_STEP) return seg(52, -14, 350, 50);
			else if (tc <= 600 * C_STEP) return seg(38, -10, 400, 200);
			else if (tc <= 800 * C_STEP) return seg(28, -2, 600, 200);
			else return seg(26, -26, 800, 400);
		endfunction

		// the 129..200 C heat segment is anchored at 121 C
		function line_seg_t heat_seg(longint tc);
			if (tc <= 20 * C_STEP) return seg(1530, 0, 20, 1);
			else if (tc <= 99 * C_STEP) return seg(1530, 240, 20, 79);
			else if (tc <= 109 * C_STEP) return seg(1770, 11830, 99, 10);
			else if (tc <= 119 * C_STEP) return seg(13600, -100, 109, 10);
			else if (tc <= 129 * C_STEP) return seg(13500, -11380, 119, 10);
			else if (tc <= 200 * C_STEP) return seg(2120, -120, 121, 79);
			else if (tc <= 250 * C_STEP) return seg(2000, -380, 200, 50);
			else if (tc <= 300 * C_STEP) return seg(1620, -910, 250, 50);
			else if (tc <= 350 * C_STEP) return seg(710, 140, 300, 50);
			else if (tc <= 400 * C_STEP) return seg(850, 150, 350, 50);
			else if (tc <= 600 * C_STEP) return seg(1000, 400, 400, 200);
			else if (tc <= 800 * C_STEP) return seg(1400, 250, 600, 200);
			else return seg(1650, 0, 800, 1);
		endfunction

		// exact rational interpolation, rounded half up to the result unit
		function longint interp(line_seg_t s, longint tc, longint yd, longint scale,
				longint mult);
			longint span_t, dt, num, den;
			span_t = s.span * C_STEP;
			dt = (s.dy == 0) ? 0 : tc - s.t0 * C_STEP;
			num = (s.y0 * span_t + s.dy * dt) * scale * mult;
			den = span_t * yd;
			if (num < 0)
				num = 0;
			return (num + den / 2) / den;
		endfunction

		function props_t predict_props(logic [TEMP_W-1:0] temp);
			props_t p;
			longint tc, rho;
			tc = longint'(temp) * 100 - KELVIN_OFS;
			p = '0;
			if (tc > 1200 * C_STEP) begin
				p.oor = 1'b1;
				return p;
			end
			if (tc <= 100 * C_STEP)
				rho = (dry_density * (65536 + moisture) + 128) >>> 8;
			else
				rho = interp(dens_seg(tc), tc, 100, 256, dry_density);
			p.cond = COND_W'(interp(cond_seg(tc), tc, 100, 65536, 1));
			p.dens = DENS_W'(rho);
			p.heat = HEAT_W'(interp(heat_seg(tc), tc, 1, 16, 1));
			return p;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_DRY_DENSITY: dry_density = data[DRY_W-1:0];
				CFG_MOISTURE:    moisture = data[MOIST_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_sample(logic [TEMP_W-1:0] temp);
			expected_props.push_back(predict_props(temp));
		endfunction

		function void check_result(props_t got);
			props_t want;
			if (expected_props.size() == 0) begin
				report("unexpected result, cond", got.cond, 0);
				return;
			end
			want = expected_props.pop_front();
			if (got.cond !== want.cond) report("conductivity", got.cond, want.cond);
			if (got.dens !== want.dens) report("density", got.dens, want.dens);
			if (got.heat !== want.heat) report("specific_heat", got.heat, want.heat);
			if (got.oor !== want.oor) report("out_of_range", got.oor, want.oor);
		endfunction

		function int pending();
			return expected_props.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  sample_valid;
	logic                  sample_stall;
	logic [TEMP_W-1:0]     temp_kelvin;
	logic                  result_valid;
	logic                  result_stall;
	logic [COND_W-1:0]     conductivity;
	logic [DENS_W-1:0]     density;
	logic [HEAT_W-1:0]     specific_heat;
	logic                  out_of_range;

	thermal_scoreboard sb = new;
	int cycles = 0;
	int hold_asked = 0;
	int hold_given = 0;
	int directed_bps[9] = '{0, 1, 2, 3, 4, 6, 7, 14, 15};

	timber_thermal_property_tables uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.temp_kelvin  (temp_kelvin),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.conductivity (conductivity),
		.density      (density),
		.specific_heat(specific_heat),
		.out_of_range (out_of_range)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// transaction monitors
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready)
			sb.set_reg(cfg_index, cfg_data);
		if (arst_n && sample_valid && !sample_stall)
			sb.note_sample(temp_kelvin);
		if (arst_n && result_valid && !result_stall)
			sb.check_result('{conductivity, density, specific_heat, out_of_range});
	end

	// output stall pattern: random modes, plus long hold-offs on request
	initial begin : result_stall_gen
		int seg_left, mode, hold_left;
		seg_left = 0;
		mode = 0;
		hold_left = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asked != hold_given) begin
				hold_given++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				if (seg_left == 0) begin
					mode = $urandom_range(0, 3);
					seg_left = $urandom_range(8, 80);
				end
				seg_left--;
				case (mode)
					0: result_stall <= 1'b0;
					1: result_stall <= ($urandom_range(0, 3) == 0);
					2: result_stall <= ($urandom_range(0, 3) != 0);
					default: result_stall <= seg_left[2];
				endcase
			end
		end
	end

	function automatic int bp_celsius(int i);
		case (i)
			0: return 20;
			1: return 99;
			2: return 100;
			3: return 109;
			4: return 119;
			5: return 121;
			6: return 129;
			7: return 200;
			8: return 250;
			9: return 300;
			10: return 350;
			11: return 400;
			12: return 500;
			13: return 600;
			14: return 800;
			default: return 1200;
		endcase
	endfunction

	// mostly the curve range, with weight on breakpoints and the heat spike
	function automatic logic [TEMP_W-1:0] random_temp();
		int pick;
		longint t;
		pick = $urandom_range(0, 9);
		if (pick < 5)
			t = $urandom_range(0, 94400);
		else if (pick < 7)
			t = 64 * bp_celsius($urandom_range(0, 15)) + ZERO_C_RAW
				+ longint'($urandom_range(0, 6)) - 3;
		else if (pick < 8)
			t = 64 * 99 + ZERO_C_RAW + longint'($urandom_range(0, 64 * 30));
		else
			t = $urandom_range(0, 131071);
		return t[TEMP_W-1:0];
	endfunction

	task automatic send_sample(logic [TEMP_W-1:0] t);
		sample_valid <= 1'b1;
		temp_kelvin <= t;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
	endtask

	task automatic run_random(int count);
		int left, burst, gap;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 32);
			if (burst > left)
				burst = left;
			left -= burst;
			repeat (burst) send_sample(random_temp());
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				sample_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic apply_setting(logic [CFG_DATA_W-1:0] dry_word,
			logic [CFG_DATA_W-1:0] moist_word, bit spare);
		write_reg(CFG_DRY_DENSITY, dry_word);
		write_reg(CFG_MOISTURE, moist_word);
		if (spare) begin
			write_reg(CFG_SPARE_2, 16'($urandom));
			write_reg(CFG_SPARE_3, 16'($urandom));
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_DRY_DENSITY;
		cfg_data <= '0;
		sample_valid <= 1'b0;
		temp_kelvin <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers still at reset values
		run_random(120);

		drain();
		apply_setting(16'hFFFF, 16'hFFFF, 1'b0);
		send_sample('0);
		send_sample('1);
		foreach (directed_bps[i]) begin
			send_sample(TEMP_W'(64 * bp_celsius(directed_bps[i]) + ZERO_C_RAW));
			send_sample(TEMP_W'(64 * bp_celsius(directed_bps[i]) + ZERO_C_RAW + 1));
		end
		run_random(150);

		// fill the block while the output is held off
		drain();
		apply_setting(16'h03FF, 16'h0000, 1'b0);
		hold_asked++;
		repeat (60) send_sample(random_temp());
		run_random(120);

		drain();
		apply_setting(16'hFC00, 16'hFFFF, 1'b0);
		run_random(150);

		for (int p = 0; p < 4; p++) begin
			drain();
			apply_setting(16'($urandom), 16'($urandom), p == 0);
			run_random(85);
			drain();
			run_random(85);
		end

		drain();
		apply_setting(16'h0001, 16'h0001, 1'b0);
		run_random(150);

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
